FILE: rtl/core/smm_pkg.sv
package smm_pkg;

  localparam int SMM_MAX_DIM   = 16;
  localparam int SMM_ELEM_BITS = 16;
  localparam int VALUE_BITS    = 16;
  localparam int PRODUCT_BITS  = 36;
  localparam int INDEX_BITS    = 4;
  localparam int SIZE_BITS     = 3;

  localparam logic [SIZE_BITS-1:0] SIZE_LOG2_RESET = 3'd4;

  localparam logic [1:0] FUNC_WRITE_A = 2'd0;
  localparam logic [1:0] FUNC_WRITE_B = 2'd1;
  localparam logic [1:0] FUNC_READ    = 2'd2;

  typedef enum logic [1:0] {
    SMM_IDLE,
    SMM_ISSUE,
    SMM_FINISH
  } smm_state_t;

  typedef struct packed {
    logic [1:0]                   func;
    logic [INDEX_BITS-1:0]        row;
    logic [INDEX_BITS-1:0]        col;
    logic signed [VALUE_BITS-1:0] value;
  } req_beat_t;

  typedef struct packed {
    logic signed [PRODUCT_BITS-1:0] product;
    logic                           bad_index;
  } rsp_beat_t;

endpackage

FILE: rtl/core/smm_mac.sv
module smm_mac import smm_pkg::*; #(
  parameter int ELEM_BITS = SMM_ELEM_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clear,
  input  logic                           ab_valid,
  input  logic signed [ELEM_BITS-1:0]    a,
  input  logic signed [ELEM_BITS-1:0]    b,
  output logic signed [PRODUCT_BITS-1:0] acc,
  output logic                           busy
);

  logic signed [2*ELEM_BITS-1:0] prod;
  logic                          prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ab_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ab_valid) begin
      prod <= (2*ELEM_BITS)'(a) * (2*ELEM_BITS)'(b);
    end
    if (clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + PRODUCT_BITS'(prod);
    end
  end

  assign busy = prod_valid;

endmodule

FILE: rtl/core/square_matrix_multiply.sv
// Square matrix multiplier, side 2^size_log2 (capped at MAX_DIM). Write beats (func 0/1)
// store one element of A or B; a write outside the side in use is dropped. A read beat
// (func 2) computes C[row][col] as a dot product, one multiply-accumulate per cycle fed by
// the single read port of each element memory, through the memory read registers, the
// product register and the accumulator; the input stalls until the result sits in the
// output register. An out-of-range read skips the accumulation and returns 0 with
// bad_index. size_log2 resets to 4; the user must see that it is written only while the
// block is idle, as the block itself does not enforce this.
module square_matrix_multiply import smm_pkg::*; #(
  parameter int MAX_DIM   = SMM_MAX_DIM,
  parameter int ELEM_BITS = SMM_ELEM_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_beat_t            req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_beat_t            rsp,
  input  logic                 cfg_we,
  input  logic [SIZE_BITS-1:0] cfg_wdata
);

  localparam int DIM_BITS  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SIDE_BITS = DIM_BITS + 1;
  localparam int CMP_BITS  = (SIDE_BITS > INDEX_BITS) ? SIDE_BITS : INDEX_BITS;
  localparam int ADDR_BITS = 2 * DIM_BITS;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;

  logic [SIZE_BITS-1:0] size_log2;
  logic [SIDE_BITS-1:0] side;
  logic                 in_range;
  logic                 req_take;
  logic [DIM_BITS-1:0]  req_row;
  logic [DIM_BITS-1:0]  req_col;
  logic [ELEM_BITS-1:0] elem;

  smm_state_t           state;
  smm_state_t           state_next;
  logic [DIM_BITS-1:0]  k;
  logic [DIM_BITS-1:0]  row_q;
  logic [DIM_BITS-1:0]  col_q;
  logic                 bad_q;
  logic                 rd_valid;
  logic                 last_k;
  logic                 load_rsp;
  logic                 mac_clear;
  logic                 mac_busy;

  logic [ELEM_BITS-1:0] mem_a [DEPTH];
  logic [ELEM_BITS-1:0] mem_b [DEPTH];
  logic [ELEM_BITS-1:0] a_rd;
  logic [ELEM_BITS-1:0] b_rd;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [ADDR_BITS-1:0] a_addr;
  logic [ADDR_BITS-1:0] b_addr;

  logic signed [PRODUCT_BITS-1:0] acc;

  assign side = (size_log2 >= SIZE_BITS'(DIM_BITS)) ? SIDE_BITS'(MAX_DIM)
                                                    : (SIDE_BITS'(1) << size_log2);
  assign in_range = (CMP_BITS'(req.row) < CMP_BITS'(side)) &&
                    (CMP_BITS'(req.col) < CMP_BITS'(side));
  assign req_take = req_valid && !req_stall;
  assign req_row  = DIM_BITS'(req.row);
  assign req_col  = DIM_BITS'(req.col);
  assign elem     = ELEM_BITS'(req.value);
  assign wr_addr  = {req_row, req_col};
  assign a_addr   = {row_q, k};
  assign b_addr   = {k, col_q};
  assign last_k   = (SIDE_BITS'({1'b0, k}) == (side - SIDE_BITS'(1)));
  assign req_stall = (state != SMM_IDLE);
  assign mac_clear = req_take && (req.func == FUNC_READ);

  always_comb begin
    state_next = state;
    load_rsp   = 1'b0;
    case (state)
      SMM_IDLE: begin
        if (req_take && (req.func == FUNC_READ)) begin
          state_next = in_range ? SMM_ISSUE : SMM_FINISH;
        end
      end
      SMM_ISSUE: begin
        if (last_k) begin
          state_next = SMM_FINISH;
        end
      end
      SMM_FINISH: begin
        if (!rd_valid && !mac_busy && (!rsp_valid || !rsp_stall)) begin
          load_rsp   = 1'b1;
          state_next = SMM_IDLE;
        end
      end
      default: begin
        state_next = SMM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SMM_IDLE;
      size_log2 <= SIZE_LOG2_RESET;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      k         <= '0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == SMM_ISSUE);
      if (cfg_we) begin
        size_log2 <= cfg_wdata;
      end
      if (mac_clear) begin
        k <= '0;
      end else if (state == SMM_ISSUE) begin
        k <= k + DIM_BITS'(1);
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mac_clear) begin
      row_q <= req_row;
      col_q <= req_col;
      bad_q <= !in_range;
    end
    if (load_rsp) begin
      rsp.product   <= acc;
      rsp.bad_index <= bad_q;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take && in_range && (req.func == FUNC_WRITE_A)) begin
      mem_a[wr_addr] <= elem;
    end
    a_rd <= mem_a[a_addr];
  end

  always_ff @(posedge clk) begin
    if (req_take && in_range && (req.func == FUNC_WRITE_B)) begin
      mem_b[wr_addr] <= elem;
    end
    b_rd <= mem_b[b_addr];
  end

  smm_mac #(
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .clear    (mac_clear),
    .ab_valid (rd_valid),
    .a        (a_rd),
    .b        (b_rd),
    .acc      (acc),
    .busy     (mac_busy)
  );

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.bad_index) |-> (rsp.product == '0))
    else $error("bad_index result with nonzero product");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (req_take && (req.func == FUNC_READ)) |=> (state != SMM_IDLE))
    else $error("read beat did not start a computation");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    (state == SMM_ISSUE) |-> (SIDE_BITS'({1'b0, k}) < side))
    else $error("dot product index beyond side");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (state == SMM_FINISH && rd_valid) |=> (state == SMM_FINISH))
    else $error("result loaded before accumulation drained");

endmodule
